/* rtl/multi_channel_heartbeat_monitor_defines.svh */
// Assertion macros shared by the heartbeat monitor RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef MULTI_CHANNEL_HEARTBEAT_MONITOR_DEFINES_SVH
`define MULTI_CHANNEL_HEARTBEAT_MONITOR_DEFINES_SVH

// Same-cycle implication.
`define MCHB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MCHB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mchb_pkg.sv */
// Shared types and constants of the heartbeat monitor.
// No dependencies; used by every module of the block.
package mchb_pkg;

	localparam int DEVICES       = 11;
	localparam int TIME_BITS     = 32;
	localparam int IDX_BITS      = $clog2(DEVICES);
	localparam int DEV_BITS      = 4;
	localparam int LIMIT_BITS    = 16;
	localparam int GAP_BITS      = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [LIMIT_BITS-1:0] RST_LIMIT_FIRST = 16'd50;
	localparam logic [LIMIT_BITS-1:0] RST_LIMIT_REST  = 16'd1000;
	localparam logic [LIMIT_BITS-1:0] RST_WARMUP      = 16'd5000;
	localparam logic [GAP_BITS-1:0]   RST_GAP         = GAP_BITS'(1);
	localparam logic [GAP_BITS-1:0]   GAP_MAX         = {GAP_BITS{1'b1}};

	localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_FIRST = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_REST  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE      = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WARMUP      = 2'd3;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_BEAT,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic                dev_ok;
		logic [DEV_BITS-1:0] dev;
	} cmd_t;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] limit_first;
		logic [LIMIT_BITS-1:0] limit_rest;
		logic [DEVICES-1:0]    enable;
		logic [LIMIT_BITS-1:0] warmup;
	} cfg_t;

	// Clamp an interval to the width of the reported worst interval.
	function automatic logic [GAP_BITS-1:0] sat_gap(input logic [TIME_BITS-1:0] gap);
		logic [63:0] wide;
		wide = 64'(gap);
		if (wide > 64'(GAP_MAX)) begin
			sat_gap = GAP_MAX;
		end else begin
			sat_gap = GAP_BITS'(wide);
		end
	endfunction

endpackage

/* rtl/mchb_front.sv */
// Front end of the heartbeat monitor: accepts requests, classifies them
// and holds them in a two-entry command queue. Depends on mchb_pkg.
module mchb_front import mchb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                req_type,
	input  logic [DEV_BITS-1:0] device,
	output logic                cmd_vld,
	input  logic                cmd_rdy,
	output cmd_t                cmd
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       do_push;
	logic       do_pop;

	// A heartbeat for a device that does not exist changes nothing.
	always_comb begin
		cls.dev    = device;
		cls.dev_ok = (32'(device) < DEVICES);
		if (!req_type) begin
			cls.kind = CMD_TICK;
		end else if (cls.dev_ok) begin
			cls.kind = CMD_BEAT;
		end else begin
			cls.kind = CMD_NOP;
		end
	end

	assign full    = (cnt_q == 2'd2);
	assign cmd_vld = (cnt_q != 2'd0);
	assign cmd     = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = cmd_vld && cmd_rdy;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/mchb_back.sv */
// Back end of the heartbeat monitor: runs heartbeat stamps and the
// per-tick device scan, and holds the result register. Depends on mchb_pkg.
`include "multi_channel_heartbeat_monitor_defines.svh"
module mchb_back import mchb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 cmd_vld,
	output logic                 cmd_rdy,
	input  cmd_t                 cmd,
	output logic                 empty,
	input  logic                 pop,
	output logic [DEVICES-1:0]   error_flags,
	output logic                 any_error,
	output logic                 device_error,
	output logic [GAP_BITS-1:0]  worst_interval
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_DRAIN,
		ST_HB_RD,
		ST_HB_WR,
		ST_RES
	} state_t;

	state_t                state_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [IDX_BITS-1:0]   scan_idx_q;
	logic [DEV_BITS-1:0]   dev_q;
	logic                  dev_ok_q;
	logic [DEVICES-1:0]    offline_q;
	logic                  any_q;
	logic                  out_vld_q;
	logic [DEVICES-1:0]    out_flags_q;
	logic                  out_any_q;
	logic                  out_dev_err_q;
	logic [GAP_BITS-1:0]   out_worst_q;
	logic                  res_load;

	// Per-device stores; an entry whose valid bit is clear reads as its reset value.
	logic [TIME_BITS-1:0]  latest_mem   [DEVICES];
	logic [TIME_BITS-1:0]  previous_mem [DEVICES];
	logic [GAP_BITS-1:0]   gap_mem      [DEVICES];
	logic [DEVICES-1:0]    beat_vld_q;
	logic [DEVICES-1:0]    gap_vld_q;

	logic [IDX_BITS-1:0]   rd_addr;
	logic [IDX_BITS-1:0]   dev_idx;
	logic                  beat_wr;
	logic                  gap_wr;

	// Stage 2: read data of one entry.
	logic                  v_s2;
	logic [IDX_BITS-1:0]   idx_s2;
	logic [TIME_BITS-1:0]  lat_rd_s2;
	logic [TIME_BITS-1:0]  prv_rd_s2;
	logic                  bvld_s2;
	logic [GAP_BITS-1:0]   gap_rd_s2;
	logic                  gvld_s2;

	logic [TIME_BITS-1:0]  lat_eff;
	logic [TIME_BITS-1:0]  prv_eff;
	logic [GAP_BITS-1:0]   gap_eff;
	logic [LIMIT_BITS-1:0] limit_s2;
	logic [TIME_BITS-1:0]  silence;

	// Stage 3: classified entry, written back.
	logic                  v_s3;
	logic [IDX_BITS-1:0]   idx_s3;
	logic                  en_s3;
	logic                  over_s3;
	logic                  grow_s3;
	logic [GAP_BITS-1:0]   gapv_s3;
	logic [GAP_BITS-1:0]   gap_old_s3;

	assign dev_idx = IDX_BITS'(dev_q);
	assign rd_addr = (state_q == ST_SCAN) ? scan_idx_q : dev_idx;
	assign cmd_rdy = (state_q == ST_IDLE);
	assign beat_wr = (state_q == ST_HB_WR);
	assign gap_wr  = v_s3 && en_s3 && !over_s3 && grow_s3 && (gapv_s3 > gap_old_s3);

	// A new result is loaded when the result register is free or being read out.
	assign res_load = (state_q == ST_RES) && (!out_vld_q || pop);

	assign lat_eff  = bvld_s2 ? lat_rd_s2 : '0;
	assign prv_eff  = bvld_s2 ? prv_rd_s2 : '0;
	assign gap_eff  = gvld_s2 ? gap_rd_s2 : RST_GAP;
	assign limit_s2 = (idx_s2 == '0) ? cfg.limit_first : cfg.limit_rest;
	assign silence  = now_q - lat_eff;

	always_ff @(posedge clk) begin
		lat_rd_s2 <= latest_mem[rd_addr];
		prv_rd_s2 <= previous_mem[rd_addr];
		gap_rd_s2 <= gap_mem[rd_addr];
		bvld_s2   <= beat_vld_q[rd_addr];
		gvld_s2   <= gap_vld_q[rd_addr];
		idx_s2    <= rd_addr;
		if (beat_wr) begin
			previous_mem[dev_idx] <= lat_eff;
			latest_mem[dev_idx]   <= now_q;
		end
		if (gap_wr) begin
			gap_mem[idx_s3] <= gapv_s3;
		end
		idx_s3     <= idx_s2;
		en_s3      <= cfg.enable[idx_s2];
		over_s3    <= (silence > TIME_BITS'(limit_s2));
		grow_s3    <= (lat_eff > prv_eff) && (now_q > TIME_BITS'(cfg.warmup));
		gapv_s3    <= sat_gap(lat_eff - prv_eff);
		gap_old_s3 <= gap_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			beat_vld_q <= '0;
			gap_vld_q  <= '0;
		end else begin
			v_s2 <= (state_q == ST_SCAN);
			v_s3 <= v_s2;
			if (beat_wr) begin
				beat_vld_q[dev_idx] <= 1'b1;
			end
			if (gap_wr) begin
				gap_vld_q[idx_s3] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			now_q         <= '0;
			scan_idx_q    <= '0;
			dev_q         <= '0;
			dev_ok_q      <= 1'b0;
			offline_q     <= '0;
			any_q         <= 1'b0;
			out_vld_q     <= 1'b0;
			out_flags_q   <= '0;
			out_any_q     <= 1'b0;
			out_dev_err_q <= 1'b0;
			out_worst_q   <= '0;
		end else begin
			if (res_load) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
			if (v_s3 && en_s3) begin
				offline_q[idx_s3] <= over_s3;
				if (over_s3) begin
					any_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_vld) begin
						dev_q    <= cmd.dev;
						dev_ok_q <= cmd.dev_ok;
						case (cmd.kind)
							CMD_TICK: state_q <= ST_TICK;
							CMD_BEAT: state_q <= ST_HB_RD;
							default:  state_q <= ST_RES;
						endcase
					end
				end
				ST_TICK: begin
					now_q      <= now_q + TIME_BITS'(1);
					any_q      <= 1'b0;
					scan_idx_q <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_idx_q == IDX_BITS'(DEVICES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_BITS'(1);
					end
				end
				ST_DRAIN: begin
					// The read issued in the cycle the pipeline is empty sees every write.
					if (!v_s2 && !v_s3) begin
						state_q <= ST_RES;
					end
				end
				ST_HB_RD: begin
					state_q <= ST_HB_WR;
				end
				ST_HB_WR: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (res_load) begin
						out_flags_q   <= offline_q;
						out_any_q     <= any_q;
						out_dev_err_q <= dev_ok_q && offline_q[dev_idx];
						out_worst_q   <= dev_ok_q ? gap_eff : '0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty          = !out_vld_q;
	assign error_flags    = out_flags_q;
	assign any_error      = out_any_q;
	assign device_error   = out_dev_err_q;
	assign worst_interval = out_worst_q;

	`MCHB_ASSERT_NXT(a_scan_start, state_q == ST_TICK, scan_idx_q == '0 && !any_q && state_q == ST_SCAN, "scan did not start from a clean state")
	`MCHB_ASSERT_IMP(a_idle_drained, cmd_rdy, !v_s2 && !v_s3, "command taken while the scan pipeline is busy")
	`MCHB_ASSERT_NXT(a_result_held, out_vld_q && !pop, out_vld_q && $stable(out_worst_q), "pending result lost or changed")
	`MCHB_ASSERT_IMP(a_no_beat_in_scan, beat_wr, !v_s2 && !v_s3, "heartbeat stamp overlaps the scan")

endmodule

/* rtl/multi_channel_heartbeat_monitor.sv */
// Top level of the heartbeat monitor: configuration registers, front end
// and back end. Depends on mchb_pkg, mchb_front and mchb_back.
//
// Requests enter through push/full: req_type 0 advances time by one tick and
// scans all devices, req_type 1 stamps a heartbeat for the given device.
// Every request gives exactly one result, read through empty/pop; the result
// reports all offline flags, the any-error flag (LED drive) and the flag and
// worst heartbeat interval of the named device.
// A two-entry command queue sits between the front end and the back end, so
// up to two requests are taken while the back end is busy or a result waits.
// Back end steps per request: a tick runs start, a scan of every device
// through the scan pipeline, pipeline drain and result load; a heartbeat
// reads and then writes the device's entry and loads the result; a heartbeat
// for a nonexistent device goes straight to result load. The back end takes
// a new request only when it is through with the last one. The scan pipeline
// and its single read port make the tick the longest request.
// When the receiver stalls, the result register holds and the back end
// waits, then the queue fills and full rises.
// Reset clears time, heartbeat history, flags and worst intervals, and loads
// the default limits; no clearing pass is needed.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at once.
module multi_channel_heartbeat_monitor import mchb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     req_type,
	input  logic [DEV_BITS-1:0]      device,
	output logic                     empty,
	input  logic                     pop,
	output logic [DEVICES-1:0]       error_flags,
	output logic                     any_error,
	output logic                     device_error,
	output logic [GAP_BITS-1:0]      worst_interval,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic cmd_vld;
	logic cmd_rdy;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_first <= RST_LIMIT_FIRST;
			cfg_q.limit_rest  <= RST_LIMIT_REST;
			cfg_q.enable      <= '1;
			cfg_q.warmup      <= RST_WARMUP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIMIT_FIRST: cfg_q.limit_first <= LIMIT_BITS'(cfg_wdata);
				CFG_LIMIT_REST:  cfg_q.limit_rest  <= LIMIT_BITS'(cfg_wdata);
				CFG_ENABLE:      cfg_q.enable      <= cfg_wdata[DEVICES-1:0];
				CFG_WARMUP:      cfg_q.warmup      <= LIMIT_BITS'(cfg_wdata);
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	mchb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.device   (device),
		.cmd_vld  (cmd_vld),
		.cmd_rdy  (cmd_rdy),
		.cmd      (cmd)
	);

	mchb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd_vld        (cmd_vld),
		.cmd_rdy        (cmd_rdy),
		.cmd            (cmd),
		.empty          (empty),
		.pop            (pop),
		.error_flags    (error_flags),
		.any_error      (any_error),
		.device_error   (device_error),
		.worst_interval (worst_interval)
	);

endmodule
